>>> hw/rtl/byte_stuffing_frame_encoder_assert.svh
// Assertion macros used by the encoder top level.
`ifndef BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH
`define BYTE_STUFFING_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define BSFE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define BSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bsfe_pkg.sv
`timescale 1ns / 1ps
package bsfe_pkg;

    localparam logic [7:0] START_BYTE = 8'h5E;
    localparam logic [7:0] END_BYTE   = 8'h24;
    localparam logic [7:0] ESC_BYTE   = 8'h5C;
    localparam logic [7:0] FLIP_MASK  = 8'h20;
    localparam logic [7:0] NL_BYTE    = 8'h0A;

    // Classified item as held in the queue between front and back.
    typedef struct packed {
        logic       has_start;
        logic       esc;
        logic       has_end;
        logic [7:0] first_byte;   // escape byte or the payload itself
        logic [7:0] second_byte;  // flipped payload, sent only when escaped
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/bsfe_if.sv
`timescale 1ns / 1ps
interface bsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source(output valid, data_byte, first_of_frame, last_of_frame, input ready);
    modport sink(input valid, data_byte, first_of_frame, last_of_frame, output ready);
endinterface

interface bsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source(output valid, out_byte, last_of_run, input ready);
    modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

>>> hw/rtl/byte_stuffing_frame_encoder.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                      Handshake
// i_in      in   data_byte[7:0], first_of_frame, last_of_frame valid/ready
// o_out     out  out_byte[7:0], last_of_run                    valid/ready
//
// Each item yields 1 to 5 output bytes, one per cycle from the back sequencer
// while the output is not stalled; its byte count is 1 + first + escaped + 2*last.
// Input is taken every cycle while the command queue has room.
// Synchronous active-low reset empties the queue and the output register.
// A stalled output fills the queue, then input ready drops.
module byte_stuffing_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsfe_in_if.sink    i_in,
    bsfe_out_if.source o_out
);
    import bsfe_pkg::*;

`include "byte_stuffing_frame_encoder_assert.svh"

    t_cmd    w_push_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    bsfe_front u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    bsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    bsfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    `BSFE_ASSERT_IMPL(a_ready_only_when_room, i_clk, i_rst_n, !i_in.ready, w_q_stat.full, "input stalled while queue has room")
    `BSFE_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")
    `BSFE_ASSERT_IMPL(a_last_not_code, i_clk, i_rst_n, o_out.valid && o_out.last_of_run, (o_out.out_byte != START_BYTE) && (o_out.out_byte != ESC_BYTE), "transaction ends on start or escape byte")
    `BSFE_ASSERT_NEXT(a_esc_followed, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.out_byte == ESC_BYTE, o_out.valid, "escape byte without its pair")
endmodule

>>> hw/rtl/bsfe_front.sv
`timescale 1ns / 1ps
module bsfe_front (
    bsfe_in_if.sink          i_in,
    input  bsfe_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output bsfe_pkg::t_cmd   o_cmd
);
    import bsfe_pkg::*;

    logic w_special;

    // Bytes that collide with framing codes must be escaped.
    assign w_special = i_in.data_byte inside {START_BYTE, END_BYTE, ESC_BYTE};

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        o_cmd.has_start   = i_in.first_of_frame;
        o_cmd.has_end     = i_in.last_of_frame;
        o_cmd.esc         = w_special;
        o_cmd.first_byte  = w_special ? ESC_BYTE : i_in.data_byte;
        o_cmd.second_byte = i_in.data_byte ^ FLIP_MASK;
    end
endmodule

>>> hw/rtl/bsfe_queue.sv
`timescale 1ns / 1ps
module bsfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bsfe_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output bsfe_pkg::t_cmd    o_head,
    output bsfe_pkg::t_q_stat o_stat
);
    import bsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

>>> hw/rtl/bsfe_back.sv
`timescale 1ns / 1ps
module bsfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsfe_pkg::t_cmd    i_head,
    input  bsfe_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    bsfe_out_if.source        o_out
);
    import bsfe_pkg::*;

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_DATA  = 3'd1;
    localparam logic [2:0] ST_FLIP  = 3'd2;
    localparam logic [2:0] ST_END   = 3'd3;
    localparam logic [2:0] ST_NL    = 3'd4;

    logic [2:0] r_step, n_step;
    logic [2:0] w_cur;
    logic [7:0] w_byte;
    logic       w_done;
    logic       w_load;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Skip the start byte for items that do not open a frame.
    assign w_cur = (r_step == ST_START && !i_head.has_start) ? ST_DATA : r_step;

    always_comb begin
        w_byte = NL_BYTE;
        w_done = 1'b0;
        n_step = ST_START;
        case (w_cur)
            ST_START: begin
                w_byte = START_BYTE;
                n_step = ST_DATA;
            end
            ST_DATA: begin
                w_byte = i_head.first_byte;
                if (i_head.esc) begin
                    n_step = ST_FLIP;
                end else if (i_head.has_end) begin
                    n_step = ST_END;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_FLIP: begin
                w_byte = i_head.second_byte;
                if (i_head.has_end) begin
                    n_step = ST_END;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_END: begin
                w_byte = END_BYTE;
                n_step = ST_NL;
            end
            ST_NL: begin
                w_byte = NL_BYTE;
                w_done = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    // Load the output register whenever the queue holds an item and the register is free or being drained.
    assign w_load = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop  = w_load && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= ST_START;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_step  <= w_done ? ST_START : n_step;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_last <= w_done;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_last;
endmodule
